### hw/rtl/v4ialu_pkg.sv
// ----------------------------------------------------------------------------
// v4ialu_pkg
// Shared types, opcodes and sizes of the four-lane vector interpolation ALU.
// ----------------------------------------------------------------------------
package v4ialu_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int LANES = 4;
  localparam int LANE_W = 16;
  localparam int SCALAR_W = 36;
  localparam int TERM_W = 64;

  typedef enum logic [3:0] {
    OP_MIN     = 4'd0,
    OP_MAX     = 4'd1,
    OP_CLAMP   = 4'd2,
    OP_LERP    = 4'd3,
    OP_SMOOTH  = 4'd4,
    OP_BARY    = 4'd5,
    OP_CATMULL = 4'd6,
    OP_HERMITE = 4'd7,
    OP_DOT     = 4'd8,
    OP_DISTSQ  = 4'd9,
    OP_LENSQ   = 4'd10
  } op_t;

  // Weights shared by all lanes; t, t2w have 14 fraction bits, s28/tsq/tcu 28.
  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [16:0] t;
    logic signed [16:0] t2w;
    logic signed [47:0] s28;
    logic signed [47:0] tsq;
    logic signed [47:0] tcu;
  } coef_t;

endpackage

### hw/rtl/v4ialu_coef.sv
// ----------------------------------------------------------------------------
// v4ialu_coef
// Weight stage: powers of t and the smoothstep weight, two registered steps.
// ----------------------------------------------------------------------------
module v4ialu_coef (
  input  logic                 clk,
  input  logic                 en0,
  input  logic                 en1,
  input  logic [3:0]           cmd,
  input  logic signed [15:0]   amount_one,
  input  logic signed [15:0]   amount_two,
  output v4ialu_pkg::coef_t    coef
);

  logic signed [16:0] ts;
  logic signed [31:0] tsq0;
  logic signed [31:0] tss0;
  logic [3:0]         cmd0;
  logic signed [16:0] t0;
  logic signed [16:0] t2w0;
  logic signed [16:0] ts0;
  logic signed [47:0] cu_full;
  logic signed [47:0] sm_full;
  logic signed [47:0] rnd14;

  assign ts = (amount_one < 0) ? 17'sd0 :
              (amount_one > 16'sd16384) ? 17'sd16384 : 17'(amount_one);
  assign rnd14 = 48'sd8192;

  always_ff @(posedge clk) begin
    if (en0) begin
      cmd0 <= cmd;
      t0   <= 17'(amount_one);
      t2w0 <= 17'(amount_two);
      ts0  <= ts;
      tsq0 <= 32'(amount_one) * 32'(amount_one);
      tss0 <= 32'(ts) * 32'(ts);
    end
  end

  assign cu_full = 48'(tsq0) * 48'(t0) + rnd14;
  assign sm_full = 48'(tss0) * (48'sd49152 - 48'(ts0) * 48'sd2) + rnd14;

  always_ff @(posedge clk) begin
    if (en1) begin
      coef.cmd <= cmd0;
      coef.t   <= t0;
      coef.t2w <= t2w0;
      coef.tsq <= 48'(tsq0);
      coef.tcu <= cu_full >>> 14;
      coef.s28 <= sm_full >>> 14;
    end
  end

endmodule

### hw/rtl/v4ialu_lane.sv
// ----------------------------------------------------------------------------
// v4ialu_lane
// One component lane: selection ops, weighted sums and the scalar term.
// ----------------------------------------------------------------------------
module v4ialu_lane (
  input  logic                 clk,
  input  logic                 en0,
  input  logic                 en1,
  input  logic                 en2,
  input  logic [15:0]          a_in,
  input  logic [15:0]          b_in,
  input  logic [15:0]          c_in,
  input  logic [15:0]          d_in,
  input  v4ialu_pkg::coef_t    coef,
  output logic [15:0]          comp,
  output logic signed [33:0]   term
);

  localparam int CB = v4ialu_pkg::COMPONENT_BITS;
  localparam logic signed [63:0] HI = 64'sd2 ** (CB - 1) - 64'sd1;
  localparam logic signed [63:0] LO = -(64'sd2 ** (CB - 1));

  logic signed [17:0] a, b, c, d;
  logic signed [17:0] a0, b0, c0, d0;
  logic signed [17:0] a1, b1, c1, d1;
  logic signed [17:0] sel;
  logic signed [17:0] sel1;
  logic signed [17:0] sel2;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [63:0] acc;
  logic signed [63:0] r;
  logic signed [33:0] sq;
  logic signed [33:0] sq1;
  logic [3:0]         cmd1;

  assign a = 18'(signed'(a_in[CB-1:0]));
  assign b = 18'(signed'(b_in[CB-1:0]));
  assign c = 18'(signed'(c_in[CB-1:0]));
  assign d = 18'(signed'(d_in[CB-1:0]));

  always_ff @(posedge clk) begin
    if (en0) begin
      a0 <= a; b0 <= b; c0 <= c; d0 <= d;
    end
    if (en1) begin
      a1 <= a0; b1 <= b0; c1 <= c0; d1 <= d0;
    end
  end

  // coef is aligned with the lane's second register stage
  always_comb begin
    sel = a1;
    sq  = '0;
    p0 = '0; p1 = '0; p2 = '0; p3 = '0;
    case (coef.cmd)
      v4ialu_pkg::OP_MIN:   sel = (a1 < b1) ? a1 : b1;
      v4ialu_pkg::OP_MAX:   sel = (a1 > b1) ? a1 : b1;
      v4ialu_pkg::OP_CLAMP: begin
        sel = (a1 > c1) ? c1 : a1;
        sel = (sel < b1) ? b1 : sel;
      end
      v4ialu_pkg::OP_LERP: begin
        p0 = 64'(a1) <<< 14;
        p1 = 64'(b1 - a1) * 64'(coef.t);
      end
      v4ialu_pkg::OP_SMOOTH: begin
        p0 = 64'(a1) <<< 28;
        p1 = 64'(b1 - a1) * 64'(coef.s28);
      end
      v4ialu_pkg::OP_BARY: begin
        p0 = 64'(a1) <<< 14;
        p1 = 64'(b1 - a1) * 64'(coef.t);
        p2 = 64'(c1 - a1) * 64'(coef.t2w);
      end
      v4ialu_pkg::OP_CATMULL: begin
        p0 = 64'(b1) <<< 29;
        p1 = (64'(c1 - a1) * 64'(coef.t)) <<< 14;
        p2 = 64'(2 * 20'(a1) - 5 * 20'(b1) + 4 * 20'(c1) - 20'(d1)) * 64'(coef.tsq);
        p3 = 64'(-20'(a1) + 3 * 20'(b1) - 3 * 20'(c1) + 20'(d1)) * 64'(coef.tcu);
      end
      v4ialu_pkg::OP_HERMITE: begin
        p0 = (64'(a1) <<< 28) + 64'(b1 - a1) * (3 * 64'(coef.tsq) - 2 * 64'(coef.tcu));
        p1 = 64'(c1) * (64'(coef.tcu) - 2 * 64'(coef.tsq));
        p2 = (64'(c1) * 64'(coef.t)) <<< 14;
        p3 = 64'(d1) * (64'(coef.tcu) - 64'(coef.tsq));
      end
      v4ialu_pkg::OP_DOT:    sq = 34'(a1) * 34'(b1);
      v4ialu_pkg::OP_DISTSQ: sq = 34'(a1 - b1) * 34'(a1 - b1);
      v4ialu_pkg::OP_LENSQ:  sq = 34'(a1) * 34'(a1);
      default: sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd1 <= coef.cmd;
      sel1 <= sel;
      sq1  <= sq;
      acc  <= p0 + p1 + p2 + p3;
    end
  end

  always_comb begin
    case (cmd1)
      v4ialu_pkg::OP_LERP, v4ialu_pkg::OP_BARY: r = (acc + 64'sd8192) >>> 14;
      v4ialu_pkg::OP_SMOOTH, v4ialu_pkg::OP_HERMITE:
        r = (acc + (64'sd1 <<< 27)) >>> 28;
      v4ialu_pkg::OP_CATMULL: r = (acc + (64'sd1 <<< 28)) >>> 29;
      default: r = 64'(sel1);
    endcase
    sel2 = (r > HI) ? 18'(HI) : (r < LO) ? 18'(LO) : 18'(r);
    comp = (cmd1 <= 4'(v4ialu_pkg::OP_HERMITE)) ? sel2[15:0] : 16'd0;
    term = sq1;
  end

endmodule

### hw/rtl/vector4_interpolation_alu.sv
// ----------------------------------------------------------------------------
// vector4_interpolation_alu
// Four-lane Q8.8 vector ALU: min/max/clamp, interpolation and squared norms.
// ----------------------------------------------------------------------------
// An accepted input word passes the input, weight, sum and output registers in order.
// Throughput: one word per cycle while the output word is taken; four-deep pipeline.
// Stages stall together when the output word is not taken.
// Reset: rst clears the stage valid flags; data registers are not reset.
module vector4_interpolation_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // cmd[3:0], vec_a[67:4], vec_b[131:68], vec_c[195:132], vec_d[259:196],
  // amount_one[275:260], amount_two[291:276], zero fill to 296
  input  logic [295:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // vec_result[63:0], scalar_result[99:64], zero fill to 104
  output logic [103:0] m_tdata
);

  logic [3:0]               vld;
  logic [3:0]               en;
  v4ialu_pkg::coef_t        coef;
  logic [15:0]              comp [v4ialu_pkg::LANES];
  logic signed [33:0]       term [v4ialu_pkg::LANES];
  logic [63:0]              vres;
  logic signed [35:0]       scal;

  // stage k advances when downstream of it has room
  assign en[3] = !vld[3] || m_tready;
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
    end
  end

  v4ialu_coef u_coef (
    .clk(clk), .en0(en[0]), .en1(en[1]),
    .cmd(s_tdata[3:0]),
    .amount_one(s_tdata[275:260]), .amount_two(s_tdata[291:276]),
    .coef(coef)
  );

  for (genvar i = 0; i < v4ialu_pkg::LANES; i++) begin : g_lane
    v4ialu_lane u_lane (
      .clk(clk), .en0(en[0]), .en1(en[1]), .en2(en[2]),
      .a_in(s_tdata[4 + 16*i +: 16]),
      .b_in(s_tdata[68 + 16*i +: 16]),
      .c_in(s_tdata[132 + 16*i +: 16]),
      .d_in(s_tdata[196 + 16*i +: 16]),
      .coef(coef),
      .comp(comp[i]),
      .term(term[i])
    );
    assign vres[16*i +: 16] = comp[i];
  end

  assign scal = 36'(term[0]) + 36'(term[1]) + 36'(term[2]) + 36'(term[3]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m_tdata <= {4'd0, scal, vres};
    end
  end

  assign m_tvalid = vld[3];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output lost");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready) else $error("stalled with empty output");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tdata[103:100] == 4'd0 || !m_tvalid) else $error("fill bits set");

endmodule

### dv/tb_vector4_interpolation_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector4_interpolation_alu
// Self-checking bench: drives random and corner-case words with random gaps
// and output stalls, predicts every result in place and compares field-wise.
// ----------------------------------------------------------------------------
module tb_vector4_interpolation_alu;

  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [63:0] vec;
    logic [35:0] scal;
  } alu_result_t;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint lane_val(logic [63:0] v, int i);
    logic [15:0] f;
    f = v[16*i +: 16];
    return longint'($signed(f));
  endfunction

  function automatic alu_result_t predict_alu(logic [3:0] cmd, logic [63:0] va,
      logic [63:0] vb, logic [63:0] vc, logic [63:0] vd, logic [15:0] w1,
      logic [15:0] w2);
    alu_result_t res;
    longint t, tw, ts, s28, tsq, tcu, a, b, c, d, r, acc, one28, h1, h2, h3, h4;
    longint scal;
    one28 = longint'(1) <<< 28;
    t = longint'($signed(w1));
    tw = longint'($signed(w2));
    ts = t < 0 ? 0 : (t > 16384 ? 16384 : t);
    s28 = rnd_shift(ts * ts * (3 * 16384 - 2 * ts), 14);
    tsq = t * t;
    tcu = rnd_shift(tsq * t, 14);
    res.vec = '0;
    scal = 0;
    for (int i = 0; i < 4; i++) begin
      a = lane_val(va, i);
      b = lane_val(vb, i);
      c = lane_val(vc, i);
      d = lane_val(vd, i);
      r = 0;
      case (cmd)
        v4ialu_pkg::OP_MIN: r = a < b ? a : b;
        v4ialu_pkg::OP_MAX: r = a > b ? a : b;
        v4ialu_pkg::OP_CLAMP: begin
          r = a > c ? c : a;
          r = r < b ? b : r;
        end
        v4ialu_pkg::OP_LERP: r = rnd_shift(a * 16384 + (b - a) * t, 14);
        v4ialu_pkg::OP_SMOOTH: r = rnd_shift(a * one28 + (b - a) * s28, 28);
        v4ialu_pkg::OP_BARY: r = rnd_shift(a * 16384 + (b - a) * t + (c - a) * tw, 14);
        v4ialu_pkg::OP_CATMULL: begin
          acc = 2 * b * one28 + (c - a) * t * 16384 + (2 * a - 5 * b + 4 * c - d) * tsq
              + (-a + 3 * b - 3 * c + d) * tcu;
          r = rnd_shift(acc, 29);
        end
        v4ialu_pkg::OP_HERMITE: begin
          h1 = 2 * tcu - 3 * tsq + one28;
          h2 = -2 * tcu + 3 * tsq;
          h3 = tcu - 2 * tsq + t * 16384;
          h4 = tcu - tsq;
          r = rnd_shift(a * h1 + b * h2 + c * h3 + d * h4, 28);
        end
        v4ialu_pkg::OP_DOT: scal += a * b;
        v4ialu_pkg::OP_DISTSQ: scal += (a - b) * (a - b);
        v4ialu_pkg::OP_LENSQ: scal += a * a;
        default: ;
      endcase
      if (cmd <= v4ialu_pkg::OP_HERMITE) begin
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        res.vec[16*i +: 16] = r[15:0];
      end
    end
    res.scal = scal[35:0];
    return res;
  endfunction

  class alu_scoreboard;
    alu_result_t pending[$];
    int errors;
    int checked;

    function void note_input(logic [295:0] w);
      pending.push_back(predict_alu(w[3:0], w[67:4], w[131:68], w[195:132],
                                    w[259:196], w[275:260], w[291:276]));
    endfunction

    function void check_result(logic [103:0] w);
      alu_result_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: %h", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (w[63:0] !== e.vec) begin
        $error("vec_result expected %h actual %h", e.vec, w[63:0]);
        errors++;
      end
      if (w[99:64] !== e.scal) begin
        $error("scalar_result expected %h actual %h", e.scal, w[99:64]);
        errors++;
      end
      if (w[103:100] !== 4'b0) begin
        $error("fill expected 0 actual %h", w[103:100]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [295:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [103:0] m_tdata;
  longint cycles = 0;
  int op_seen[16];
  alu_scoreboard sb = new();

  vector4_interpolation_alu i_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [15:0] rnd_lane();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rnd_vec();
    return {rnd_lane(), rnd_lane(), rnd_lane(), rnd_lane()};
  endfunction

  function automatic logic [15:0] rnd_weight();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'h0000;
      4: return 16'($urandom_range(16384));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [3:0] cmd, logic [63:0] va, logic [63:0] vb,
                           logic [63:0] vc, logic [63:0] vd, logic [15:0] w1,
                           logic [15:0] w2);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, w2, w1, vd, vc, vb, va, cmd};
    do @(posedge clk); while (!s_tready);
    op_seen[cmd]++;
  endtask

  task automatic send_random();
    send_word(4'($urandom_range(15) < 14 ? $urandom_range(10) : $urandom_range(15, 11)),
              rnd_vec(), rnd_vec(), rnd_vec(), rnd_vec(), rnd_weight(), rnd_weight());
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  initial begin : stall_gen
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int ops_hit;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int op = 0; op < 16; op++) begin
      send_word(4'(op), 64'h7FFF_8000_0100_FF00, 64'h8000_7FFF_FE00_0080,
                64'h0000_7FFF_8000_0200, 64'h7FFF_7FFF_8000_8000, 16'h2000, 16'h1000);
    end
    send_word(v4ialu_pkg::OP_CLAMP, 64'h0100_0100_0100_0100, 64'h0200_0000_0200_0200,
              64'h0000_0300_0000_0000, '0, '0, '0);
    send_word(v4ialu_pkg::OP_SMOOTH, 64'h0100, 64'h7FFF, '0, '0, 16'hC000, '0);
    send_word(v4ialu_pkg::OP_SMOOTH, 64'h0100, 64'h7FFF, '0, '0, 16'h7FFF, '0);
    send_word(v4ialu_pkg::OP_HERMITE, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}},
              {4{16'h8000}}, 16'h8000, 16'h7FFF);
    send_word(v4ialu_pkg::OP_CATMULL, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}},
              {4{16'h7FFF}}, 16'h7FFF, 16'h8000);
    send_word(v4ialu_pkg::OP_DOT, {4{16'h8000}}, {4{16'h8000}}, '0, '0, '0, '0);
    send_word(v4ialu_pkg::OP_DISTSQ, {4{16'h8000}}, {4{16'h7FFF}}, '0, '0, '0, '0);
    send_word(v4ialu_pkg::OP_LERP, {4{16'hFFFF}}, {4{16'hFFFF}}, {4{16'hFFFF}},
              {4{16'hFFFF}}, 16'hFFFF, 16'hFFFF);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    for (int n = 0; n < 1000; n++) send_random();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (20) @(posedge clk);
    ops_hit = 0;
    for (int op = 0; op < 16; op++) if (op_seen[op] > 0) ops_hit++;
    $display("Covered %0d results over %0d opcode values incl. undefined ones,",
             sb.checked, ops_hit);
    $display("corner lanes and weights, random gaps and output stalls.");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### vector4_interpolation_alu.f
hw/rtl/v4ialu_pkg.sv
hw/rtl/v4ialu_coef.sv
hw/rtl/v4ialu_lane.sv
hw/rtl/vector4_interpolation_alu.sv
dv/tb_vector4_interpolation_alu.sv
